// File: src/assert_macros.svh
// Assertion macros shared by the sampler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("sampler assertion failed");

// A condition that, once seen, requires a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sampler implication failed");

`endif

// File: src/bsw_pkg.sv
`timescale 1ns / 1ps
// Shared constants, state encoding and control structs of the batch sampler.
package bsw_pkg;

	localparam int TABLE_DEPTH_DEF = 65536;
	localparam int RND_W = 31;
	localparam int IDX_W = 16;
	localparam int TOT_W = 17;
	localparam logic [TOT_W-1:0] TOTAL_RESET = 17'd65536;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_DIV_LOAD,
		ST_DIV_WAIT,
		ST_RD_POS,
		ST_RD_BASE,
		ST_WR_POS,
		ST_WR_BASE,
		ST_DONE,
		ST_DROP
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic take_in;
		logic clear_stop;
		logic set_stop;
		logic restart;
		logic div_start;
		logic rd_pos;
		logic rd_base;
		logic wr_pos;
		logic wr_base;
		logic load_res;
		logic res_valid;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic first;
		logic stopped;
		logic exhausted;
		logic div_busy;
		logic res_free;
	} ctrl_stat_t;

endpackage

// File: src/bsw_div.sv
`timescale 1ns / 1ps
// Iterative restoring remainder unit, one quotient bit per cycle.
`include "assert_macros.svh"
module bsw_div import bsw_pkg::*; #(
	parameter int DEN_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RND_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             busy,
	output logic [DEN_W-1:0] rem
);

	localparam int STEP_W = $clog2(RND_W);

	logic [RND_W-1:0]  num_q;
	logic [DEN_W-1:0]  denom_q;
	logic [DEN_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;

	// Shift the next numerator bit into the partial remainder.
	assign trial = {rem_q, num_q[RND_W-1]};
	assign diff  = trial - {1'b0, denom_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(RND_W - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q   <= numer;
			denom_q <= denom;
			rem_q   <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[RND_W-2:0], 1'b0};
			if (trial >= {1'b0, denom_q}) begin
				rem_q <= diff[DEN_W-1:0];
			end else begin
				rem_q <= trial[DEN_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

	`ASSERT_IMPLIES(a_rem_below_denom, clk, arst_n, busy_q, rem_q < denom_q)

endmodule

// File: src/bsw_dp.sv
`timescale 1ns / 1ps
// Datapath: permutation memory, draw counter, remainder unit and result register.
`include "assert_macros.svh"
module bsw_dp import bsw_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	output ctrl_stat_t       stat,
	input  logic             total_wr,
	input  logic [TOT_W-1:0] total_data,
	input  logic [RND_W-1:0] random_value,
	input  logic             first_of_batch,
	input  logic             out_stall,
	output logic             out_valid,
	output logic             sample_valid,
	output logic [IDX_W-1:0] sample_index,
	output logic             pool_restarted
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int TW    = (CNT_W > TOT_W) ? CNT_W : TOT_W;

	logic [TOT_W-1:0] total_q;
	logic [CNT_W-1:0] eff_total;
	logic [CNT_W-1:0] drawn_count_q;
	logic [CNT_W-1:0] divisor;
	logic [CNT_W-1:0] rem;
	logic [CNT_W-1:0] pos_sum;
	logic [AW-1:0]    pos_addr;
	logic [AW-1:0]    base_addr;
	logic [AW-1:0]    clr_idx_q;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_data;
	logic [IDX_W-1:0] rd_data_q;
	logic [IDX_W-1:0] drawn_q;
	logic [IDX_W-1:0] mem [TABLE_DEPTH];
	logic [RND_W-1:0] rnd_q;
	logic             first_q;
	logic             stopped_q;
	logic             restarted_q;
	logic             div_busy;
	logic             out_valid_q;
	logic             sample_valid_q;
	logic [IDX_W-1:0] sample_index_q;
	logic             pool_restarted_q;

	// Zero counts as one record, anything past the table depth saturates.
	always_comb begin
		if (total_q == '0) begin
			eff_total = CNT_W'(1);
		end else if (TW'(total_q) > TW'(TABLE_DEPTH)) begin
			eff_total = CNT_W'(TABLE_DEPTH);
		end else begin
			eff_total = CNT_W'(total_q);
		end
	end

	assign divisor   = eff_total - drawn_count_q;
	assign pos_sum   = drawn_count_q + rem;
	assign pos_addr  = pos_sum[AW-1:0];
	assign base_addr = drawn_count_q[AW-1:0];

	bsw_div #(
		.DEN_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (rnd_q),
		.denom  (divisor),
		.busy   (div_busy),
		.rem    (rem)
	);

	assign rd_addr = cmd.rd_pos ? pos_addr : base_addr;
	assign wr_en   = cmd.clr_wr | cmd.wr_pos | cmd.wr_base;

	always_comb begin
		if (cmd.clr_wr) begin
			wr_addr = clr_idx_q;
			wr_data = IDX_W'(clr_idx_q);
		end else if (cmd.wr_pos) begin
			wr_addr = pos_addr;
			wr_data = rd_data_q;
		end else begin
			wr_addr = base_addr;
			wr_data = drawn_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			rnd_q   <= random_value;
			first_q <= first_of_batch;
		end
		if (cmd.rd_base) begin
			drawn_q <= rd_data_q;
		end
		if (cmd.load_res) begin
			sample_valid_q   <= cmd.res_valid;
			sample_index_q   <= cmd.res_valid ? drawn_q : '0;
			pool_restarted_q <= cmd.res_valid & restarted_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q       <= TOTAL_RESET;
			drawn_count_q <= '0;
			stopped_q     <= 1'b0;
			restarted_q   <= 1'b0;
			clr_idx_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (total_wr) begin
				total_q <= total_data;
			end
			if (cmd.restart) begin
				drawn_count_q <= '0;
			end else if (cmd.wr_base) begin
				drawn_count_q <= drawn_count_q + 1'b1;
			end
			if (cmd.clear_stop) begin
				stopped_q <= 1'b0;
			end else if (cmd.set_stop) begin
				stopped_q <= 1'b1;
			end
			if (cmd.take_in) begin
				restarted_q <= 1'b0;
			end else if (cmd.restart) begin
				restarted_q <= 1'b1;
			end
			if (cmd.clr_wr) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.clr_done  = (clr_idx_q == AW'(TABLE_DEPTH - 1));
		stat.first     = first_q;
		stat.stopped   = stopped_q;
		stat.exhausted = (drawn_count_q >= eff_total);
		stat.div_busy  = div_busy;
		stat.res_free  = !out_valid_q || !out_stall;
	end

	assign out_valid      = out_valid_q;
	assign sample_valid   = sample_valid_q;
	assign sample_index   = sample_index_q;
	assign pool_restarted = pool_restarted_q;

	`ASSERT_IMPLIES(a_swap_inside_pool, clk, arst_n, cmd.wr_base, drawn_count_q < eff_total)

endmodule

// File: src/bsw_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences clearing, decision, division and swap.
`include "assert_macros.svh"
module bsw_ctrl import bsw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  ctrl_stat_t stat,
	output logic       in_stall,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!stat.first && (stat.stopped || stat.exhausted)) begin
					state_d = ST_DROP;
				end else begin
					state_d = ST_DIV_LOAD;
				end
			end
			ST_DIV_LOAD: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (!stat.div_busy) begin
					state_d = ST_RD_POS;
				end
			end
			ST_RD_POS:  state_d = ST_RD_BASE;
			ST_RD_BASE: state_d = ST_WR_POS;
			ST_WR_POS:  state_d = ST_WR_BASE;
			ST_WR_BASE: state_d = ST_DONE;
			ST_DONE, ST_DROP: begin
				if (stat.res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.take_in = in_valid;
			end
			ST_DECIDE: begin
				// A new batch clears the stop flag and restarts an exhausted pool; mid-batch exhaustion stops it.
				if (stat.first) begin
					cmd.clear_stop = 1'b1;
					cmd.restart    = stat.exhausted;
				end else if (!stat.stopped && stat.exhausted) begin
					cmd.set_stop = 1'b1;
				end
			end
			ST_DIV_LOAD: cmd.div_start = 1'b1;
			ST_DIV_WAIT: cmd = '0;
			ST_RD_POS:   cmd.rd_pos = 1'b1;
			ST_RD_BASE:  cmd.rd_base = 1'b1;
			ST_WR_POS:   cmd.wr_pos = 1'b1;
			ST_WR_BASE:  cmd.wr_base = 1'b1;
			ST_DONE: begin
				cmd.load_res  = stat.res_free;
				cmd.res_valid = 1'b1;
			end
			ST_DROP: begin
				cmd.load_res  = stat.res_free;
				cmd.res_valid = 1'b0;
			end
			default: cmd = '0;
		endcase
	end

	`ASSERT_IMPLIES(a_busy_only_waiting, clk, arst_n, stat.div_busy, state_q == ST_DIV_WAIT)

endmodule

// File: src/batch_sampler_without_replacement_top.sv
`timescale 1ns / 1ps
// Top level: a valid draw passes from acceptance through the decision, the
// bit-serial remainder unit and four memory steps (two reads, two writes) to its
// result; no new draw is taken until the last one is through. A draw that returns
// invalid goes from the decision straight to the drop state and back to idle.
// After arst_n the permutation table is rewritten to the identity, during which
// in_stall stays high; configuration writes are taken throughout.
module batch_sampler_without_replacement_top import bsw_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [TOT_W-1:0] total_records,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [RND_W-1:0] random_value,
	input  logic             first_of_batch,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             sample_valid,
	output logic [IDX_W-1:0] sample_index,
	output logic             pool_restarted
);

	// The controller and the datapath talk only through these two structs.
	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	// The record count register accepts a write request in any cycle. It is
	// expected to change only while no draw is in flight.
	assign cfg_ready = 1'b1;

	// The controller steps through the clearing sweep, the per-draw decision
	// (batch restart or early stop), the remainder computation and the
	// two-entry swap, and releases the result into the output register.
	bsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// The datapath holds the permutation memory, the draw counter, the batch
	// stop flag and the output register. The output register lets the next
	// request be accepted while an earlier result still waits downstream.
	bsw_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.total_wr       (cfg_valid & cfg_ready),
		.total_data     (total_records),
		.random_value   (random_value),
		.first_of_batch (first_of_batch),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.sample_valid   (sample_valid),
		.sample_index   (sample_index),
		.pool_restarted (pool_restarted)
	);

endmodule
